[src/kst_pkg.sv]
// Shared types and constants for the Kelvin-notation symmetric tensor inverse.
`timescale 1ns / 1ps

package kst_pkg;

    // Word format of every field.
    localparam int WORD_BITS = 32;

    // Number of inverse components, one divider lane each.
    localparam int LANES = 6;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int LATENCY = WORD_BITS + 6;

    // Configuration port address width and register index.
    localparam int ADDR_BITS = 3;
    localparam logic [0:0] IDX_FULL_3D_MODE = 1'b0;

    // 1/sqrt(2) with 32 fraction bits.
    localparam int          KQ_FRAC       = 32;
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic        [WORD_BITS-1:0] mag_t;

    // Saturation limits as magnitudes.
    localparam mag_t NEG_MAG = mag_t'(1) << (WORD_BITS - 1);
    localparam mag_t POS_MAG = NEG_MAG - mag_t'(1);

    // A value after saturation and whether it was clipped.
    typedef struct packed {
        logic  clip;
        word_t val;
    } sat_t;

    // One tensor in Kelvin notation.
    typedef struct packed {
        word_t in_xx;
        word_t in_yy;
        word_t in_zz;
        word_t in_xy;
        word_t in_yz;
        word_t in_xz;
    } in_word_t;

    // Inverse, determinant and flags.
    typedef struct packed {
        word_t out_xx;
        word_t out_yy;
        word_t out_zz;
        word_t out_xy;
        word_t out_yz;
        word_t out_xz;
        word_t det_value;
        logic  singular;
        logic  saturated;
    } out_word_t;

    // State of one restoring-divider lane.
    typedef struct packed {
        logic [WORD_BITS:0] rem;
        mag_t               quo;
        mag_t               num;
        logic               neg;
        logic               over;
    } lane_t;

endpackage

[src/kelvin_symmetric_tensor_inverse.sv]
// Pipelined inverse and determinant of a symmetric 3x3 tensor in Kelvin notation.
// A word accepted at one edge passes the input stage, stages A to D, the divider stages
// and the output register before it is shown on result with done high.
// Throughput: one word per cycle; busy never rises and results cannot be held off.
// The latency is set by the restoring divider, which resolves one quotient bit per stage.
// Reset clears all valid bits and sets full_3d_mode to 1.
`timescale 1ns / 1ps

module kelvin_symmetric_tensor_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  kst_pkg::in_word_t                  operand,
    output logic                               done,
    output kst_pkg::out_word_t                 result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kst_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int W = kst_pkg::WORD_BITS;
    localparam int L = kst_pkg::LANES;

    // Arithmetic helpers.

    function automatic kst_pkg::mag_t mag_of(input kst_pkg::word_t x);
        return x[W-1] ? kst_pkg::mag_t'(-x) : kst_pkg::mag_t'(x);
    endfunction

    function automatic kst_pkg::sat_t from_mag(input logic neg, input logic [2*W-1:0] mag);
        logic [2*W-1:0] lim;
        kst_pkg::mag_t  m;
        kst_pkg::sat_t  r;
        lim = neg ? {{W{1'b0}}, kst_pkg::NEG_MAG} : {{W{1'b0}}, kst_pkg::POS_MAG};
        r.clip = (mag > lim);
        m = r.clip ? lim[W-1:0] : mag[W-1:0];
        r.val = neg ? -$signed(m) : $signed(m);
        return r;
    endfunction

    function automatic kst_pkg::sat_t mq(input kst_pkg::word_t a, input kst_pkg::word_t b);
        logic [2*W-1:0] pr;
        logic [2*W-1:0] rs;
        pr = {{W{1'b0}}, mag_of(a)} * {{W{1'b0}}, mag_of(b)};
        rs = (pr + ((2*W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return from_mag(a[W-1] ^ b[W-1], rs);
    endfunction

    function automatic kst_pkg::word_t kq(input kst_pkg::word_t x);
        logic [W+kst_pkg::KQ_FRAC-1:0] pr;
        logic [W+kst_pkg::KQ_FRAC-1:0] rs;
        kst_pkg::mag_t                 m;
        pr = {{kst_pkg::KQ_FRAC{1'b0}}, mag_of(x)}
           * {{W{1'b0}}, kst_pkg::INV_SQRT2_Q32};
        rs = (pr + ((W + kst_pkg::KQ_FRAC)'(1) << (kst_pkg::KQ_FRAC - 1)))
           >> kst_pkg::KQ_FRAC;
        m = rs[W-1:0];
        return x[W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic kst_pkg::word_t hq(input kst_pkg::word_t x);
        kst_pkg::mag_t m;
        m = (mag_of(x) + kst_pkg::mag_t'(1)) >> 1;
        return x[W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [W+2:0] sx(input kst_pkg::word_t x);
        return {{3{x[W-1]}}, x};
    endfunction

    function automatic kst_pkg::sat_t sat_sum(input logic signed [W+2:0] s);
        logic [W+2:0] m;
        m = s[W+2] ? (W+3)'(-s) : (W+3)'(s);
        return from_mag(s[W+2], (2*W)'(m));
    endfunction

    function automatic kst_pkg::lane_t div_step(input kst_pkg::lane_t x, input logic b,
                                                input kst_pkg::mag_t d);
        logic [W:0]     sh;
        kst_pkg::lane_t r;
        r  = x;
        sh = {x.rem[W-1:0], b};
        if (sh >= {1'b0, d})
        begin
            r.rem = sh - {1'b0, d};
            r.quo = {x.quo[W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh;
            r.quo = {x.quo[W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Configuration register.
    logic mode_reg;
    logic cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[kst_pkg::ADDR_BITS-1:2] == kst_pkg::IDX_FULL_3D_MODE)
                       ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_write && paddr[kst_pkg::ADDR_BITS-1:2] == kst_pkg::IDX_FULL_3D_MODE)
            mode_reg <= pwdata[0];
    end

    assign busy = 1'b0;

    // Input stage: capture the word, dropping the out-of-plane shears in plane mode.
    logic              i_v_reg;
    logic              i_mode_reg;
    kst_pkg::in_word_t i_reg;
    kst_pkg::in_word_t op_masked;

    always_comb
    begin
        op_masked = operand;
        if (!mode_reg)
        begin
            op_masked.in_yz = '0;
            op_masked.in_xz = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_v_reg <= 1'b0;
        else
            i_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            i_reg      <= op_masked;
            i_mode_reg <= mode_reg;
        end
    end

    // Stage A: the pairwise products that the adjugate and the determinant use.
    kst_pkg::sat_t p_xxyy, p_yyzz, p_xxzz, p_xyyz, p_xyxy, p_yzyz;
    kst_pkg::sat_t p_xzxz, p_yzxz, p_xyxz, p_xyzz, p_yzxx, p_yyxz;
    logic          a_clip_next;

    logic          a_v_reg, a_mode_reg, a_clip_reg;
    kst_pkg::word_t a_xxyy_reg, a_yyzz_reg, a_xxzz_reg, a_xyyz_reg, a_xyxy_reg, a_yzyz_reg;
    kst_pkg::word_t a_xzxz_reg, a_yzxz_reg, a_xyxz_reg, a_xyzz_reg, a_yzxx_reg, a_yyxz_reg;
    kst_pkg::word_t a_xx_reg, a_yy_reg, a_zz_reg, a_xz_reg;

    always_comb
    begin
        p_xxyy = mq(i_reg.in_xx, i_reg.in_yy);
        p_yyzz = mq(i_reg.in_yy, i_reg.in_zz);
        p_xxzz = mq(i_reg.in_xx, i_reg.in_zz);
        p_xyyz = mq(i_reg.in_xy, i_reg.in_yz);
        p_xyxy = mq(i_reg.in_xy, i_reg.in_xy);
        p_yzyz = mq(i_reg.in_yz, i_reg.in_yz);
        p_xzxz = mq(i_reg.in_xz, i_reg.in_xz);
        p_yzxz = mq(i_reg.in_yz, i_reg.in_xz);
        p_xyxz = mq(i_reg.in_xy, i_reg.in_xz);
        p_xyzz = mq(i_reg.in_xy, i_reg.in_zz);
        p_yzxx = mq(i_reg.in_yz, i_reg.in_xx);
        p_yyxz = mq(i_reg.in_yy, i_reg.in_xz);
        // Products with the dropped shears are zero in plane mode and never clip.
        a_clip_next = p_xxyy.clip | p_yyzz.clip | p_xxzz.clip | p_xyyz.clip
                    | p_xyxy.clip | p_yzyz.clip | p_xzxz.clip | p_yzxz.clip
                    | p_xyxz.clip | p_xyzz.clip | p_yzxx.clip | p_yyxz.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= i_v_reg;
    end

    always_ff @(posedge clk)
    begin
        a_mode_reg <= i_mode_reg;
        a_clip_reg <= a_clip_next;
        a_xxyy_reg <= p_xxyy.val;
        a_yyzz_reg <= p_yyzz.val;
        a_xxzz_reg <= p_xxzz.val;
        a_xyyz_reg <= p_xyyz.val;
        a_xyxy_reg <= p_xyxy.val;
        a_yzyz_reg <= p_yzyz.val;
        a_xzxz_reg <= p_xzxz.val;
        a_yzxz_reg <= p_yzxz.val;
        a_xyxz_reg <= p_xyxz.val;
        a_xyzz_reg <= p_xyzz.val;
        a_yzxx_reg <= p_yzxx.val;
        a_yyxz_reg <= p_yyxz.val;
        a_xx_reg   <= i_reg.in_xx;
        a_yy_reg   <= i_reg.in_yy;
        a_zz_reg   <= i_reg.in_zz;
        a_xz_reg   <= i_reg.in_xz;
    end

    // Stage B: triple products, halves, scaled shears and the plane minor.
    kst_pkg::sat_t t1, t2, t3, t4, t5, p_minor;
    kst_pkg::word_t h_xyxy, b_clip_dummy_unused;
    logic          b_clip_next;

    logic           b_v_reg, b_mode_reg, b_clip_reg;
    kst_pkg::word_t b_t1_reg, b_t2_reg, b_t3_reg, b_t4_reg, b_t5_reg, b_p_reg;
    kst_pkg::word_t b_hyzyz_reg, b_hxzxz_reg;
    kst_pkg::word_t b_kyzxz_reg, b_kxyxz_reg, b_kxyyz_reg;
    kst_pkg::word_t b_yyzz_reg, b_xxzz_reg, b_xyzz_reg, b_yzxx_reg, b_yyxz_reg, b_zz_reg;

    always_comb
    begin
        t1      = mq(a_xxyy_reg, a_zz_reg);
        t2      = mq(a_xyyz_reg, a_xz_reg);
        t3      = mq(a_xyxy_reg, a_zz_reg);
        t4      = mq(a_yzyz_reg, a_xx_reg);
        t5      = mq(a_xzxz_reg, a_yy_reg);
        h_xyxy  = hq(a_xyxy_reg);
        b_clip_dummy_unused = h_xyxy;
        p_minor = sat_sum(sx(a_xxyy_reg) - sx(b_clip_dummy_unused));
        // The minor serves both forms; the triple products only the full form.
        b_clip_next = a_clip_reg | p_minor.clip
                    | (a_mode_reg & (t1.clip | t2.clip | t3.clip | t4.clip | t5.clip));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        b_mode_reg  <= a_mode_reg;
        b_clip_reg  <= b_clip_next;
        b_t1_reg    <= t1.val;
        b_t2_reg    <= t2.val;
        b_t3_reg    <= t3.val;
        b_t4_reg    <= t4.val;
        b_t5_reg    <= t5.val;
        b_p_reg     <= p_minor.val;
        b_hyzyz_reg <= hq(a_yzyz_reg);
        b_hxzxz_reg <= hq(a_xzxz_reg);
        b_kyzxz_reg <= kq(a_yzxz_reg);
        b_kxyxz_reg <= kq(a_xyxz_reg);
        b_kxyyz_reg <= kq(a_xyyz_reg);
        b_yyzz_reg  <= a_yyzz_reg;
        b_xxzz_reg  <= a_xxzz_reg;
        b_xyzz_reg  <= a_xyzz_reg;
        b_yzxx_reg  <= a_yzxx_reg;
        b_yyxz_reg  <= a_yyxz_reg;
        b_zz_reg    <= a_zz_reg;
    end

    // Stage C: adjugate in either form, plane determinant, terms of the full determinant.
    kst_pkg::sat_t  s_adj0, s_adj1, s_adj3, s_adj4, s_adj5, s_nxyzz, s_dplane;
    kst_pkg::word_t c_adj_next [L];
    logic           c_clip_next;

    logic           c_v_reg, c_mode_reg, c_clip_reg;
    kst_pkg::word_t c_adj_reg [L];
    kst_pkg::word_t c_dplane_reg, c_t1_reg, c_k2_reg, c_h3_reg, c_h4_reg, c_h5_reg;

    always_comb
    begin
        s_adj0   = sat_sum(sx(b_yyzz_reg) - sx(b_hyzyz_reg));
        s_adj1   = sat_sum(sx(b_xxzz_reg) - sx(b_hxzxz_reg));
        s_adj3   = sat_sum(sx(b_kyzxz_reg) - sx(b_xyzz_reg));
        s_adj4   = sat_sum(sx(b_kxyxz_reg) - sx(b_yzxx_reg));
        s_adj5   = sat_sum(sx(b_kxyyz_reg) - sx(b_yyxz_reg));
        s_nxyzz  = sat_sum(-sx(b_xyzz_reg));
        s_dplane = mq(b_zz_reg, b_p_reg);
        if (b_mode_reg)
        begin
            c_adj_next[0] = s_adj0.val;
            c_adj_next[1] = s_adj1.val;
            c_adj_next[2] = b_p_reg;
            c_adj_next[3] = s_adj3.val;
            c_adj_next[4] = s_adj4.val;
            c_adj_next[5] = s_adj5.val;
            c_clip_next   = b_clip_reg | s_adj0.clip | s_adj1.clip | s_adj3.clip
                          | s_adj4.clip | s_adj5.clip;
        end
        else
        begin
            c_adj_next[0] = b_yyzz_reg;
            c_adj_next[1] = b_xxzz_reg;
            c_adj_next[2] = b_p_reg;
            c_adj_next[3] = s_nxyzz.val;
            c_adj_next[4] = '0;
            c_adj_next[5] = '0;
            c_clip_next   = b_clip_reg | s_nxyzz.clip | s_dplane.clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        c_mode_reg   <= b_mode_reg;
        c_clip_reg   <= c_clip_next;
        c_adj_reg    <= c_adj_next;
        c_dplane_reg <= s_dplane.val;
        c_t1_reg     <= b_t1_reg;
        c_k2_reg     <= kq(b_t2_reg);
        c_h3_reg     <= hq(b_t3_reg);
        c_h4_reg     <= hq(b_t4_reg);
        c_h5_reg     <= hq(b_t5_reg);
    end

    // Stage D: determinant and divider set-up.
    kst_pkg::sat_t  s_d3;
    kst_pkg::word_t det_next;
    kst_pkg::mag_t  dmag_next;
    logic           d_clip_next;
    kst_pkg::lane_t lane0_next [L];

    always_comb
    begin
        s_d3 = sat_sum(sx(c_t1_reg) + sx(c_k2_reg) - sx(c_h3_reg) - sx(c_h4_reg)
                       - sx(c_h5_reg));
        det_next    = c_mode_reg ? s_d3.val : c_dplane_reg;
        d_clip_next = c_clip_reg | (c_mode_reg & s_d3.clip);
        dmag_next   = mag_of(det_next);
        for (int l = 0; l < L; l++)
        begin
            lane0_next[l].num  = mag_of(c_adj_reg[l]);
            lane0_next[l].neg  = c_adj_reg[l][W-1] ^ det_next[W-1];
            lane0_next[l].rem  = (W+1)'(lane0_next[l].num >> (W - FRAC_BITS));
            // Quotient of 2**W or more saturates whatever its low bits are.
            lane0_next[l].over = lane0_next[l].rem >= {1'b0, dmag_next};
            lane0_next[l].quo  = '0;
        end
    end

    // Divider pipeline: index 0 holds the set-up, index W the finished quotients.
    logic           dv_reg    [W+1];
    kst_pkg::word_t det_s_reg [W+1];
    kst_pkg::mag_t  dmag_reg  [W+1];
    logic           clip_s_reg [W+1];
    kst_pkg::lane_t lane_reg  [W+1][L];
    kst_pkg::lane_t lane_next [W][L];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else
            dv_reg[0] <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        det_s_reg[0]  <= det_next;
        dmag_reg[0]   <= dmag_next;
        clip_s_reg[0] <= d_clip_next;
        lane_reg[0]   <= lane0_next;
    end

    for (genvar s = 0; s < W; s++)
    begin : g_div
        localparam int BIT = W - 1 - s;

        // One quotient bit per stage for every lane.
        if (BIT >= FRAC_BITS)
        begin : g_num
            always_comb
            begin
                for (int l = 0; l < L; l++)
                    lane_next[s][l] = div_step(lane_reg[s][l],
                                               lane_reg[s][l].num[BIT-FRAC_BITS],
                                               dmag_reg[s]);
            end
        end
        else
        begin : g_pad
            always_comb
            begin
                for (int l = 0; l < L; l++)
                    lane_next[s][l] = div_step(lane_reg[s][l], 1'b0, dmag_reg[s]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s+1] <= 1'b0;
            else
                dv_reg[s+1] <= dv_reg[s];
        end

        always_ff @(posedge clk)
        begin
            det_s_reg[s+1]  <= det_s_reg[s];
            dmag_reg[s+1]   <= dmag_reg[s];
            clip_s_reg[s+1] <= clip_s_reg[s];
            lane_reg[s+1]   <= lane_next[s];
        end
    end

    // Output stage: round, saturate, zero on a singular tensor.
    kst_pkg::sat_t      q_sat [L];
    logic [W:0]         q_round [L];
    logic               sing_next;
    logic               div_clip_next;
    kst_pkg::out_word_t result_next;
    kst_pkg::out_word_t result_reg;
    logic               done_reg;

    always_comb
    begin
        sing_next     = (det_s_reg[W] == '0);
        div_clip_next = 1'b0;
        for (int l = 0; l < L; l++)
        begin
            q_round[l] = {1'b0, lane_reg[W][l].quo}
                       + (W+1)'({lane_reg[W][l].rem, 1'b0} >= {2'b00, dmag_reg[W]});
            q_sat[l]   = from_mag(lane_reg[W][l].neg,
                                  lane_reg[W][l].over ? {(2*W){1'b1}} : (2*W)'(q_round[l]));
            div_clip_next = div_clip_next | q_sat[l].clip;
        end
        result_next.out_xx    = sing_next ? '0 : q_sat[0].val;
        result_next.out_yy    = sing_next ? '0 : q_sat[1].val;
        result_next.out_zz    = sing_next ? '0 : q_sat[2].val;
        result_next.out_xy    = sing_next ? '0 : q_sat[3].val;
        result_next.out_yz    = sing_next ? '0 : q_sat[4].val;
        result_next.out_xz    = sing_next ? '0 : q_sat[5].val;
        result_next.det_value = det_s_reg[W];
        result_next.singular  = sing_next;
        result_next.saturated = clip_s_reg[W] | (!sing_next & div_clip_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_reg[W];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/kst_checker.sv]
// Port-level checks for the tensor inverse, bound to the top level.
`timescale 1ns / 1ps

module kst_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input kst_pkg::out_word_t result
);

    localparam int LAT = kst_pkg::LATENCY;

    // Every accepted word yields a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("accepted word gave no result after the pipeline latency");

    // No result appears without a word accepted the latency before.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result with no matching accepted word");

    // A singular tensor reports a zero determinant and a zero inverse.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.singular |-> result.det_value == '0 && result.out_xx == '0
            && result.out_yy == '0 && result.out_zz == '0 && result.out_xy == '0
            && result.out_yz == '0 && result.out_xz == '0)
        else $error("singular result with nonzero fields");

    // A zero determinant is always flagged singular.
    a_regular_det: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.singular |-> result.det_value != '0)
        else $error("zero determinant not flagged singular");

endmodule

bind kelvin_symmetric_tensor_inverse kst_checker u_kst_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
